// ===== src/permutation_pair_canonicalizer_macros.svh =====
// Assertion macros for the permutation pair canonicalizer.
`ifndef PERMUTATION_PAIR_CANONICALIZER_MACROS_SVH
`define PERMUTATION_PAIR_CANONICALIZER_MACROS_SVH
`ifndef SYNTHESIS
`define PPC_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PPC_ASSERT_IMPL(label, clk, rst, ante, cons)
`define PPC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== src/ppc_pkg.sv =====
// Shared types and constants of the permutation pair canonicalizer.
`default_nettype none
package ppc_pkg;
  localparam int unsigned NIB = 4;
  typedef logic [NIB-1:0] nib_t;
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CHECK = 9'b000000010,
    S_COMP  = 9'b000000100,
    S_ROOT  = 9'b000001000,
    S_BFS   = 9'b000010000,
    S_EMIT  = 9'b000100000,
    S_CMP   = 9'b001000000,
    S_SORT  = 9'b010000000,
    S_LAY   = 9'b100000000
  } state_t;
endpackage
`default_nettype wire

// ===== src/ppc_code_cmp.sv =====
// Shared nibble comparator used for code minimum and component sorting.
`default_nettype none
module ppc_code_cmp (
  input  wire ppc_pkg::nib_t a,
  input  wire ppc_pkg::nib_t b,
  output logic               lt,
  output logic               gt
);
  // Compare one code digit
  always_comb begin
    lt = (a < b);
    gt = (a > b);
  end
endmodule
`default_nettype wire

// ===== src/permutation_pair_canonicalizer.sv =====
// Permutation pair canonicalizer top level: sequencer, code store and layout.
//
// Usage: present left_perm/right_perm with in_valid; the item is taken when
// in_ready is high. One result (canonical_key, not_permutation) follows on
// out_valid/out_ready. The block handles one item at a time: in_ready is low
// from acceptance until the result is taken, and rises the cycle after that.
// Invalid permutations: out_valid rises once every point has been checked.
// A single sequencer walks each component from every root, one image
// lookup per cycle (four images per visited point), writes each candidate
// code one digit per cycle and compares it against the best one digit per
// cycle through one shared comparator. Bubble sorting at most NPOINTS/2
// codes compares one digit per cycle.
// Reset (rst, synchronous) returns the sequencer to idle and drops any item
// in flight. When the receiver stalls, the result holds in the output
// register and no new item is accepted.
`default_nettype none
`include "permutation_pair_canonicalizer_macros.svh"
module permutation_pair_canonicalizer #(
  parameter int unsigned NPOINTS = 8
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [31:0] left_perm,
  input  wire  [31:0] right_perm,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [63:0] canonical_key,
  output logic        not_permutation
);
  localparam int unsigned CL = 1 + 2 * NPOINTS;
  localparam int unsigned PW = $clog2(NPOINTS);
  localparam int unsigned CW = $clog2(CL + 1);
  typedef logic [PW-1:0] pt_t;

  ppc_pkg::state_t state;
  ppc_pkg::nib_t l [NPOINTS];
  ppc_pkg::nib_t r [NPOINTS];
  pt_t li [NPOINTS];
  pt_t ri [NPOINTS];
  logic [NPOINTS-1:0] seen_l, seen_r, unseen, comp, vis;
  logic bad;
  pt_t idx;                       // general point counter
  pt_t order [NPOINTS];
  pt_t lab   [NPOINTS];
  logic [PW:0] size, cur;
  logic [1:0] k;
  logic comp_mode;                // 1: collecting component, 0: root walk
  ppc_pkg::nib_t cand [CL];
  ppc_pkg::nib_t codes [NPOINTS][CL];
  logic [PW:0] ncomp;
  logic first;
  logic [CW-1:0] dig;
  logic [PW:0] si, sj;
  ppc_pkg::nib_t cl [NPOINTS];
  ppc_pkg::nib_t cr [NPOINTS];
  logic [PW:0] off, li2;

  // Shared comparator operands
  ppc_pkg::nib_t ca, cb;
  logic c_lt, c_gt;
  ppc_code_cmp u_cmp (.a(ca), .b(cb), .lt(c_lt), .gt(c_gt));

  logic [CW-1:0] ci;
  always_comb begin
    ci = (dig < CW'(CL)) ? dig : '0;
    if (state == ppc_pkg::S_CMP) begin
      ca = cand[ci];
      cb = codes[ncomp[PW-1:0]][ci];
    end else begin
      ca = codes[sj[PW-1:0]][ci];
      cb = codes[sj[PW-1:0] + pt_t'(1)][ci];
    end
  end

  // Lowest point not yet in a component
  pt_t seed;
  always_comb begin
    seed = '0;
    for (int i = NPOINTS - 1; i >= 0; i--)
      if (unseen[i]) seed = pt_t'(i);
  end

  // Current walk point and its selected image
  pt_t p, q;
  always_comb begin
    p = order[cur[PW-1:0]];
    case (k)
      2'd0: q = l[p][PW-1:0];
      2'd1: q = r[p][PW-1:0];
      2'd2: q = li[p];
      default: q = ri[p];
    endcase
  end

  // Code digit being emitted
  logic [PW:0] ei;
  pt_t ep;
  always_comb begin
    ei = (dig[CW-1:0] <= CW'(size)) ? (PW+1)'(dig - 1) : (PW+1)'(dig - 1 - size);
    ep = order[ei[PW-1:0]];
  end

  assign in_ready = (state == ppc_pkg::S_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ppc_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        ppc_pkg::S_IDLE: begin
          // Take a new item
          if (in_valid && in_ready) begin
            for (int i = 0; i < NPOINTS; i++) begin
              l[i] <= left_perm[4*i +: 4];
              r[i] <= right_perm[4*i +: 4];
            end
            seen_l <= '0; seen_r <= '0; bad <= 1'b0; idx <= '0;
            state <= ppc_pkg::S_CHECK;
          end
        end
        ppc_pkg::S_CHECK: begin
          // Check one point per cycle, build inverses
          if (l[idx] >= ppc_pkg::nib_t'(NPOINTS) || r[idx] >= ppc_pkg::nib_t'(NPOINTS)
              || seen_l[l[idx][PW-1:0]] || seen_r[r[idx][PW-1:0]]) bad <= 1'b1;
          seen_l[l[idx][PW-1:0]] <= 1'b1;
          seen_r[r[idx][PW-1:0]] <= 1'b1;
          li[l[idx][PW-1:0]] <= idx;
          ri[r[idx][PW-1:0]] <= idx;
          unseen[idx] <= (l[idx] != ppc_pkg::nib_t'(idx)) || (r[idx] != ppc_pkg::nib_t'(idx));
          if (idx == pt_t'(NPOINTS - 1)) begin
            ncomp <= '0;
            for (int i = 0; i < NPOINTS; i++) begin
              cl[i] <= ppc_pkg::nib_t'(i); cr[i] <= ppc_pkg::nib_t'(i);
            end
            if (bad || l[idx] >= ppc_pkg::nib_t'(NPOINTS) || r[idx] >= ppc_pkg::nib_t'(NPOINTS)
                || seen_l[l[idx][PW-1:0]] || seen_r[r[idx][PW-1:0]]) begin
              canonical_key <= '0; not_permutation <= 1'b1; out_valid <= 1'b1;
              state <= ppc_pkg::S_IDLE;
            end else state <= ppc_pkg::S_COMP;
          end else idx <= idx + pt_t'(1);
        end
        ppc_pkg::S_COMP: begin
          // Seed the next component at the lowest unseen point
          if (unseen == '0) begin
            si <= (PW+1)'(1); sj <= '0; dig <= '0;
            state <= ppc_pkg::S_SORT;
          end else begin
            order[0] <= seed; vis <= NPOINTS'(1) << seed;
            size <= (PW+1)'(1); cur <= '0; k <= '0; comp_mode <= 1'b1;
            state <= ppc_pkg::S_BFS;
          end
        end
        ppc_pkg::S_ROOT: begin
          // Start a walk from the next root in the component
          if (idx == pt_t'(NPOINTS - 1) && !comp[idx]) begin
            unseen <= unseen & ~comp; ncomp <= ncomp + 1'b1;
            state <= ppc_pkg::S_COMP;
          end else if (comp[idx]) begin
            order[0] <= idx; lab[idx] <= '0;
            vis <= NPOINTS'(1) << idx;
            size <= (PW+1)'(1); cur <= '0; k <= '0;
            state <= ppc_pkg::S_BFS;
          end else idx <= idx + pt_t'(1);
        end
        ppc_pkg::S_BFS: begin
          // One image lookup per cycle
          if (!vis[q] && (comp_mode || comp[q]) && size < (PW+1)'(NPOINTS)) begin
            vis[q] <= 1'b1;
            order[size[PW-1:0]] <= q;
            lab[q] <= size[PW-1:0];
            size <= size + 1'b1;
          end
          k <= k + 2'd1;
          if (k == 2'd3) begin
            if (cur + 1'b1 >= size + ((!vis[q] && (comp_mode || comp[q])
                && size < (PW+1)'(NPOINTS)) ? 1'b1 : 1'b0)) begin
              if (comp_mode) begin
                comp_mode <= 1'b0;
                comp <= vis | ((!vis[q] && size < (PW+1)'(NPOINTS)) ? (NPOINTS'(1) << q) : '0);
                idx <= '0; first <= 1'b1;
                state <= ppc_pkg::S_ROOT;
              end else begin
                dig <= '0; state <= ppc_pkg::S_EMIT;
              end
            end else cur <= cur + 1'b1;
          end
        end
        ppc_pkg::S_EMIT: begin
          // Write one candidate digit per cycle
          if (dig == '0) cand[0] <= ppc_pkg::nib_t'(size);
          else if (dig <= CW'(size)) cand[dig] <= ppc_pkg::nib_t'(lab[l[ep][PW-1:0]]);
          else if (dig <= CW'(2*size)) cand[dig] <= ppc_pkg::nib_t'(lab[r[ep][PW-1:0]]);
          else cand[dig] <= '0;
          if (dig == CW'(CL - 1)) begin
            dig <= '0; state <= ppc_pkg::S_CMP;
          end else dig <= dig + 1'b1;
        end
        ppc_pkg::S_CMP: begin
          // Keep the least candidate, one digit per cycle
          if (first || c_lt) begin
            for (int d = 0; d < CL; d++) codes[ncomp[PW-1:0]][d] <= cand[d];
            first <= 1'b0;
          end
          if (first || c_lt || c_gt || dig == CW'(CL - 1)) begin
            dig <= '0;
            if (idx == pt_t'(NPOINTS - 1)) begin
              unseen <= unseen & ~comp; ncomp <= ncomp + 1'b1;
              state <= ppc_pkg::S_COMP;
            end else begin
              idx <= idx + pt_t'(1); state <= ppc_pkg::S_ROOT;
            end
          end else dig <= dig + 1'b1;
        end
        ppc_pkg::S_SORT: begin
          // Bubble passes: compare adjacent codes digit by digit
          if (si >= ncomp) begin
            off <= '0; si <= '0; li2 <= '0; state <= ppc_pkg::S_LAY;
          end else if (sj + 1'b1 >= ncomp) begin
            sj <= '0; si <= si + 1'b1; dig <= '0;
          end else if (c_gt || c_lt || dig == CW'(CL - 1)) begin
            if (c_gt) begin
              codes[sj[PW-1:0]] <= codes[sj[PW-1:0] + pt_t'(1)];
              codes[sj[PW-1:0] + pt_t'(1)] <= codes[sj[PW-1:0]];
            end
            sj <= sj + 1'b1; dig <= '0;
          end else dig <= dig + 1'b1;
        end
        ppc_pkg::S_LAY: begin
          // Lay out one point of one component per cycle
          if (si >= ncomp) begin
            for (int i = 0; i < NPOINTS; i++) begin
              canonical_key[4*i +: 4] <= cl[i];
              canonical_key[32 + 4*i +: 4] <= cr[i];
            end
            for (int i = NPOINTS; i < 8; i++) begin
              canonical_key[4*i +: 4] <= '0;
              canonical_key[32 + 4*i +: 4] <= '0;
            end
            not_permutation <= 1'b0; out_valid <= 1'b1;
            state <= ppc_pkg::S_IDLE;
          end else if (li2 >= (PW+1)'(codes[si[PW-1:0]][0])) begin
            off <= off + (PW+1)'(codes[si[PW-1:0]][0]);
            li2 <= '0; si <= si + 1'b1;
          end else begin
            if (off + li2 < (PW+1)'(NPOINTS)) begin
              cl[PW'(off + li2)] <= ppc_pkg::nib_t'(off) +
                codes[si[PW-1:0]][CW'(li2) + CW'(1)];
              cr[PW'(off + li2)] <= ppc_pkg::nib_t'(off) +
                codes[si[PW-1:0]][CW'(1) + CW'(codes[si[PW-1:0]][0]) + CW'(li2)];
            end
            li2 <= li2 + 1'b1;
          end
        end
        default: state <= ppc_pkg::S_IDLE;
      endcase
    end
  end

  `PPC_ASSERT_IMPL(a_one_hot, clk, rst, 1'b1, $onehot(state))
  `PPC_ASSERT_IMPL(a_busy, clk, rst, out_valid, !in_ready)
  `PPC_ASSERT_IMPL(a_zero_key, clk, rst, out_valid && not_permutation, canonical_key == '0)
  `PPC_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(canonical_key))
endmodule
`default_nettype wire

// ===== tb/ppc_checker.sv =====
// Checker for the permutation pair canonicalizer: predicts each key and compares results.
module ppc_checker #(
  parameter int unsigned NPOINTS = 8
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  input  wire         in_ready,
  input  wire  [31:0] left_perm,
  input  wire  [31:0] right_perm,
  input  wire         out_valid,
  input  wire         out_ready,
  input  wire  [63:0] canonical_key,
  input  wire         not_permutation,
  output int          fail_count,
  output int          pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLEN = 1 + 2 * NPOINTS;

  typedef struct packed {
    logic [63:0] key;
    logic        bad;
  } canon_t;

  typedef logic [3:0] code_t [CLEN];

  canon_t key_queue[$];

  // Check that every used nibble is in range and appears once.
  function automatic bit valid_perm(input logic [31:0] word);
    logic [15:0] hit;
    logic [3:0] v;
    hit = '0;
    for (int i = 0; i < NPOINTS; i++) begin
      v = word[4*i +: 4];
      if (v >= NPOINTS || hit[v]) return 1'b0;
      hit[v] = 1'b1;
    end
    return 1'b1;
  endfunction

  // Return -1, 0 or 1 as a compares with b digit by digit.
  function automatic int code_order(input code_t a, input code_t b);
    for (int i = 0; i < CLEN; i++) begin
      if (a[i] < b[i]) return -1;
      if (a[i] > b[i]) return 1;
    end
    return 0;
  endfunction

  // Relabel one component breadth first from a chosen root.
  function automatic code_t walk_code(input logic [3:0] lp [NPOINTS],
                                      input logic [3:0] rp [NPOINTS],
                                      input logic [3:0] li [NPOINTS],
                                      input logic [3:0] ri [NPOINTS],
                                      input logic [15:0] comp, input int root);
    code_t c;
    logic [3:0] lab [NPOINTS];
    int ord [NPOINTS];
    bit seen [NPOINTS];
    int size;
    int p;
    logic [3:0] img [4];
    int q;
    for (int i = 0; i < NPOINTS; i++) begin
      lab[i] = '0;
      seen[i] = 0;
      ord[i] = 0;
    end
    for (int i = 0; i < CLEN; i++) c[i] = '0;
    size = 1;
    ord[0] = root;
    seen[root] = 1;
    for (int cur = 0; cur < size; cur++) begin
      p = ord[cur];
      img[0] = lp[p];
      img[1] = rp[p];
      img[2] = li[p];
      img[3] = ri[p];
      for (int k = 0; k < 4; k++) begin
        q = img[k];
        if (comp[q] && !seen[q] && size < NPOINTS) begin
          seen[q] = 1;
          lab[q] = size[3:0];
          ord[size] = q;
          size++;
        end
      end
    end
    c[0] = size[3:0];
    for (int i = 0; i < size; i++) begin
      c[1 + i] = lab[lp[ord[i]]];
      c[1 + size + i] = lab[rp[ord[i]]];
    end
    return c;
  endfunction

  // Compute the canonical form of one input pair.
  function automatic canon_t canon_pair(input logic [31:0] lw, input logic [31:0] rw);
    canon_t res;
    logic [3:0] lp [NPOINTS];
    logic [3:0] rp [NPOINTS];
    logic [3:0] li [NPOINTS];
    logic [3:0] ri [NPOINTS];
    code_t codes [NPOINTS];
    code_t cand;
    code_t t;
    logic [15:0] unseen;
    logic [15:0] comp;
    int ncomp;
    int pend [NPOINTS];
    int np;
    int seed;
    int p;
    int j;
    int off;
    int size;
    bit first;
    logic [3:0] cl [NPOINTS];
    logic [3:0] cr [NPOINTS];
    logic [3:0] img [4];
    res = '0;
    if (!valid_perm(lw) || !valid_perm(rw)) begin
      res.bad = 1'b1;
      return res;
    end
    unseen = '0;
    for (int i = 0; i < NPOINTS; i++) begin
      lp[i] = lw[4*i +: 4];
      rp[i] = rw[4*i +: 4];
    end
    for (int i = 0; i < NPOINTS; i++) begin
      li[lp[i]] = i[3:0];
      ri[rp[i]] = i[3:0];
      if (lp[i] != i || rp[i] != i) unseen[i] = 1'b1;
    end
    ncomp = 0;
    while (unseen != 0 && ncomp < NPOINTS) begin
      seed = 0;
      while (!unseen[seed]) seed++;
      comp = '0;
      comp[seed] = 1'b1;
      pend[0] = seed;
      np = 1;
      for (int cur = 0; cur < np; cur++) begin
        p = pend[cur];
        img[0] = lp[p];
        img[1] = rp[p];
        img[2] = li[p];
        img[3] = ri[p];
        for (int k = 0; k < 4; k++) begin
          if (!comp[img[k]] && np < NPOINTS) begin
            comp[img[k]] = 1'b1;
            pend[np] = img[k];
            np++;
          end
        end
      end
      unseen &= ~comp;
      first = 1;
      for (int k = 0; k < NPOINTS; k++) begin
        if (comp[k]) begin
          cand = walk_code(lp, rp, li, ri, comp, k);
          if (first || code_order(cand, codes[ncomp]) < 0) begin
            codes[ncomp] = cand;
            first = 0;
          end
        end
      end
      ncomp++;
    end
    // sort the component codes
    for (int i = 1; i < ncomp; i++) begin
      t = codes[i];
      j = i - 1;
      while (j >= 0 && code_order(codes[j], t) > 0) begin
        codes[j + 1] = codes[j];
        j--;
      end
      codes[j + 1] = t;
    end
    for (int i = 0; i < NPOINTS; i++) begin
      cl[i] = i[3:0];
      cr[i] = i[3:0];
    end
    off = 0;
    for (int i = 0; i < ncomp; i++) begin
      size = codes[i][0];
      for (int m = 0; m < size && off + m < NPOINTS; m++) begin
        cl[off + m] = off[3:0] + codes[i][1 + m];
        cr[off + m] = off[3:0] + codes[i][1 + size + m];
      end
      off += size;
    end
    for (int i = 0; i < NPOINTS; i++) begin
      res.key[4*i +: 4] = cl[i];
      res.key[32 + 4*i +: 4] = cr[i];
    end
    return res;
  endfunction

  assign pending_count = key_queue.size();

  // Predict on each accepted input item, compare on each accepted result.
  always @(posedge clk) begin
    canon_t want;
    if (rst) begin
      key_queue.delete();
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready) key_queue = {key_queue, canon_pair(left_perm, right_perm)};
      if (out_valid && out_ready) begin
        if (key_queue.size() == 0) begin
          $display("%0t: result with none expected: key %h bad %b", $time,
                   canonical_key, not_permutation);
          fail_count <= fail_count + 1;
        end else begin
          want = key_queue.pop_front();
          if (want.key !== canonical_key || want.bad !== not_permutation) begin
            $display("%0t: mismatch: expected key %h bad %b, got key %h bad %b",
                     $time, want.key, want.bad, canonical_key, not_permutation);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== tb/tb.sv =====
// Testbench top for the permutation pair canonicalizer: stimulus and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPOINTS = 8;
  localparam int ITEMS = 450;
  localparam longint LIMIT = 3000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] left_perm = '0;
  logic [31:0] right_perm = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] canonical_key;
  logic        not_permutation;
  int          fail_count;
  int          pending_count;
  longint      cycle_count = 0;
  logic [31:0] lq[$];
  logic [31:0] rq[$];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  permutation_pair_canonicalizer #(.NPOINTS(NPOINTS)) dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .left_perm(left_perm), .right_perm(right_perm), .out_valid(out_valid),
    .out_ready(out_ready), .canonical_key(canonical_key),
    .not_permutation(not_permutation)
  );

  ppc_checker #(.NPOINTS(NPOINTS)) u_checker (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .left_perm(left_perm), .right_perm(right_perm), .out_valid(out_valid),
    .out_ready(out_ready), .canonical_key(canonical_key),
    .not_permutation(not_permutation), .fail_count(fail_count),
    .pending_count(pending_count)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    if ($urandom_range(0, 9) < 3) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
    return $urandom_range(0, 4);
  endfunction

  // Random permutation, optionally restricted to a few moved points.
  function automatic logic [31:0] rand_perm(input int moved);
    logic [3:0] p [NPOINTS];
    logic [3:0] tmp;
    logic [31:0] w;
    int j;
    for (int i = 0; i < NPOINTS; i++) p[i] = i[3:0];
    for (int i = NPOINTS - 1; i > 0; i--) begin
      if (i < moved || moved >= NPOINTS) begin
        j = $urandom_range(0, i);
        tmp = p[i];
        p[i] = p[j];
        p[j] = tmp;
      end
    end
    w = $urandom;
    for (int i = 0; i < NPOINTS; i++) w[4*i +: 4] = p[i];
    return w;
  endfunction

  // Append one pair to the stimulus lists.
  task automatic add_pair(input logic [31:0] a, input logic [31:0] b);
    lq = {lq, a};
    rq = {rq, b};
  endtask

  // Random pair: mostly valid, some with broken or random nibbles.
  task automatic add_random();
    logic [31:0] a;
    logic [31:0] b;
    int kind;
    kind = $urandom_range(0, 19);
    a = rand_perm($urandom_range(2, NPOINTS));
    b = rand_perm($urandom_range(0, 3) == 0 ? 0 : $urandom_range(2, NPOINTS));
    if (kind == 0) a = $urandom;
    else if (kind == 1) b = $urandom;
    else if (kind == 2) a[4*$urandom_range(0, NPOINTS-1) +: 4] = 4'($urandom);
    else if (kind == 3) b[4*$urandom_range(0, NPOINTS-1) +: 4] = 4'($urandom);
    else if (kind == 4) a = b;
    add_pair(a, b);
  endtask

  // Random stall on the result side.
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 9) < 6);
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    int hold;
    int n;
    // directed pairs
    add_pair(32'h76543210, 32'h76543210);
    add_pair(32'hF6543210, 32'h76543210);
    add_pair(32'h76543210, 32'h76543288);
    add_pair(32'h07654321, 32'h76543210);
    add_pair(32'h01234567, 32'h76543210);
    add_pair(32'h07654321, 32'h70654321);
    add_pair(32'h76543201, 32'h76543120);
    add_pair(32'h67452301, 32'h76543210);
    add_pair(32'h67452301, 32'h45670123);
    add_pair(32'hFFFFFFFF, 32'hFFFFFFFF);
    add_pair(32'h00000000, 32'h00000000);
    add_pair(32'hF6543210, 32'h06543210);
    add_pair(32'h76543210, 32'h07654321);
    add_pair(32'h76543201, 32'h76452310);
    add_pair(32'h76543210, 32'h76543201);
    add_pair(32'h07654321, 32'h07654321);
    while (lq.size() < ITEMS) add_random();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    n = 0;
    while (lq.size() > 0) begin
      // present the next item and hold it until taken
      in_valid <= 1'b1;
      left_perm <= lq.pop_front();
      right_perm <= rq.pop_front();
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      n++;
      hold = gap_len();
      if (hold > 0 || lq.size() == 0 || n == ITEMS / 2) begin
        in_valid <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      // once, drain everything before going on
      if (n == ITEMS / 2) begin
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
      end
    end
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("PASS permutation_pair_canonicalizer");
    else $display("FAIL permutation_pair_canonicalizer");
    $finish;
  end

  // Stop a hung run.
  always @(posedge clk) begin
    if (cycle_count > LIMIT) begin
      $display("FAIL permutation_pair_canonicalizer");
      $finish;
    end
  end
endmodule
